// ===== src/htc_pkg.sv =====
// shared constants and types for the hysteresis thermostat controller
package htc_pkg;

  // event kinds of one request
  localparam logic [2:0] EV_POWER   = 3'd0;
  localparam logic [2:0] EV_BUTTONS = 3'd1;
  localparam logic [2:0] EV_SAMPLE  = 3'd2;
  localparam logic [2:0] EV_DISPLAY = 3'd3;
  localparam logic [2:0] EV_MODE    = 3'd4;
  localparam logic [2:0] EV_LED     = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_INIT_SETPOINT = 3'd0;
  localparam logic [2:0] CFG_BAND          = 3'd1;
  localparam logic [2:0] CFG_STEP          = 3'd2;
  localparam logic [2:0] CFG_CEILING       = 3'd3;
  localparam logic [2:0] CFG_BLINK_COUNT   = 3'd4;

  // configuration reset values
  localparam logic [6:0] INIT_SETPOINT_RST = 7'd25;
  localparam logic [3:0] BAND_RST          = 4'd5;
  localparam logic [3:0] STEP_RST          = 4'd5;
  localparam logic [6:0] CEILING_RST       = 7'd75;
  localparam logic [7:0] BLINK_COUNT_RST   = 8'd156;

  localparam logic [6:0] SETPOINT_MAX = 7'd127;

  // degrees = floor(count * 0.488) = (count * ADC_SCALE) >> ADC_SHIFT, exact for 10 bit counts
  localparam int unsigned ADC_SHIFT = 24;
  localparam logic [22:0] ADC_SCALE = 23'd8187282;

  typedef struct packed {
    logic [2:0] event_kind;
    logic       up_pressed;
    logic       down_pressed;
    logic [9:0] adc_count;
  } req_t;

  typedef struct packed {
    logic       heater_on;
    logic       cooler_on;
    logic       led_level;
    logic       display_enable;
    logic [8:0] display_value;
    logic       powered;
    logic       operating_mode;
    logic [6:0] setpoint_now;
    logic       store_strobe;
    logic [8:0] temperature_now;
  } rsp_t;

endpackage

// ===== src/hysteresis_thermostat_controller_top.sv =====
// event driven thermostat with hysteresis, display blink and heating indicator
// Each request passes an input register and then the update logic into the result
// register, so the block takes one request per clock unless it stalls. The rate is
// set by the single state update stage, which applies the sample conversion (one
// constant multiply), the hysteresis compares and the setpoint step in the same cycle.
// Throughput stalls only while the result register holds an untaken result and the
// input register is full.
// Configuration writes are always taken and should be issued only while idle.
module hysteresis_thermostat_controller_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_event_kind,
  input  logic       in_up_pressed,
  input  logic       in_down_pressed,
  input  logic [9:0] in_adc_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_heater_on,
  output logic       out_cooler_on,
  output logic       out_led_level,
  output logic       out_display_enable,
  output logic [8:0] out_display_value,
  output logic       out_powered,
  output logic       out_operating_mode,
  output logic [6:0] out_setpoint_now,
  output logic       out_store_strobe,
  output logic [8:0] out_temperature_now,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // configuration
  logic [3:0] band_r;
  logic [3:0] step_r;
  logic [6:0] ceiling_r;
  logic [7:0] blink_count_r;

  // state
  logic       power_r,    power_nxt;
  logic       mode_r,     mode_nxt;
  logic       activity_r, activity_nxt;
  logic [6:0] setpoint_r, setpoint_nxt;
  logic [8:0] temp_r,     temp_nxt;
  logic       heating_r,  heating_nxt;
  logic       heater_r,   heater_nxt;
  logic       cooler_r,   cooler_nxt;
  logic [7:0] blink_cnt_r, blink_cnt_nxt;
  logic       blink_ph_r, blink_ph_nxt;
  logic       led_r,      led_nxt;
  logic       disp_en_r,  disp_en_nxt;
  logic [8:0] disp_val_r, disp_val_nxt;
  logic       strobe_nxt;

  // pipeline
  htc_pkg::req_t req_r;
  logic          req_valid_r;
  htc_pkg::rsp_t rsp_r;
  logic          rsp_valid_r;
  logic          advance;
  logic          cfg_write;

  logic [32:0] adc_prod;
  logic [6:0]  sp_up;
  logic [7:0]  sp_sum;
  logic [9:0]  sp_hi;
  logic [9:0]  t_lo;

  assign advance   = !rsp_valid_r || out_ready;
  assign in_ready  = advance || !req_valid_r;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  assign adc_prod = {23'd0, req_r.adc_count} * {10'd0, htc_pkg::ADC_SCALE};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
    if (in_ready) begin
      req_r.event_kind   <= in_event_kind;
      req_r.up_pressed   <= in_up_pressed;
      req_r.down_pressed <= in_down_pressed;
      req_r.adc_count    <= in_adc_count;
    end
  end

  always_comb begin
    power_nxt     = power_r;
    mode_nxt      = mode_r;
    activity_nxt  = activity_r;
    setpoint_nxt  = setpoint_r;
    temp_nxt      = temp_r;
    heating_nxt   = heating_r;
    heater_nxt    = heater_r;
    cooler_nxt    = cooler_r;
    blink_cnt_nxt = blink_cnt_r;
    blink_ph_nxt  = blink_ph_r;
    led_nxt       = led_r;
    disp_en_nxt   = disp_en_r;
    disp_val_nxt  = disp_val_r;
    strobe_nxt    = 1'b0;
    sp_up         = setpoint_r;
    sp_sum        = {1'b0, setpoint_r} + {4'd0, step_r};
    sp_hi         = 10'd0;
    t_lo          = 10'd0;

    case (req_r.event_kind)
      htc_pkg::EV_POWER: begin
        if (!power_r) begin
          power_nxt = 1'b1;
        end else begin
          power_nxt    = 1'b0;
          disp_en_nxt  = 1'b0;
          disp_val_nxt = 9'd0;
          heater_nxt   = 1'b0;
          cooler_nxt   = 1'b0;
        end
      end
      htc_pkg::EV_BUTTONS: begin
        if (power_r) begin
          activity_nxt = 1'b1;
          if (req_r.up_pressed && (setpoint_r < ceiling_r)) begin
            sp_up = sp_sum[7] ? htc_pkg::SETPOINT_MAX : sp_sum[6:0];
          end
          setpoint_nxt = sp_up;
          if (req_r.down_pressed && (sp_up >= {3'd0, step_r})) begin
            setpoint_nxt = sp_up - {3'd0, step_r};
          end
        end
      end
      htc_pkg::EV_SAMPLE: begin
        temp_nxt = adc_prod[htc_pkg::ADC_SHIFT +: 9];
        sp_hi    = {3'd0, setpoint_r} + {6'd0, band_r};
        t_lo     = {1'b0, temp_nxt} + {6'd0, band_r};
        if (mode_r) begin
          if ({1'b0, temp_nxt} >= sp_hi) begin
            heater_nxt  = 1'b0;
            heating_nxt = 1'b0;
            cooler_nxt  = 1'b1;
          end
          if (t_lo < {3'd0, setpoint_r}) begin
            heater_nxt  = 1'b1;
            heating_nxt = 1'b1;
            cooler_nxt  = 1'b0;
          end
        end
      end
      htc_pkg::EV_DISPLAY: begin
        if (power_r) begin
          if (!mode_r) begin
            blink_cnt_nxt = blink_cnt_r + 8'd1;
            disp_en_nxt   = blink_ph_r;
            disp_val_nxt  = blink_ph_r ? {2'd0, setpoint_r} : 9'd0;
            if (blink_cnt_nxt == blink_count_r) begin
              blink_ph_nxt = !blink_ph_r;
            end
          end else begin
            disp_en_nxt  = 1'b1;
            disp_val_nxt = temp_r;
          end
        end
      end
      htc_pkg::EV_MODE: begin
        if (activity_r) begin
          activity_nxt = 1'b0;
          mode_nxt     = 1'b0;
        end else begin
          strobe_nxt = 1'b1;
          mode_nxt   = 1'b1;
        end
      end
      htc_pkg::EV_LED: begin
        led_nxt = heating_r ? !led_r : 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r          <= htc_pkg::BAND_RST;
      step_r          <= htc_pkg::STEP_RST;
      ceiling_r       <= htc_pkg::CEILING_RST;
      blink_count_r   <= htc_pkg::BLINK_COUNT_RST;
      power_r         <= 1'b0;
      mode_r          <= 1'b0;
      activity_r      <= 1'b1;
      setpoint_r      <= htc_pkg::INIT_SETPOINT_RST;
      temp_r          <= 9'd0;
      heating_r       <= 1'b0;
      heater_r        <= 1'b0;
      cooler_r        <= 1'b0;
      blink_cnt_r     <= 8'd0;
      blink_ph_r      <= 1'b0;
      led_r           <= 1'b0;
      disp_en_r       <= 1'b0;
      disp_val_r      <= 9'd0;
      rsp_valid_r     <= 1'b0;
    end else begin
      if (req_valid_r && advance) begin
        power_r     <= power_nxt;
        mode_r      <= mode_nxt;
        activity_r  <= activity_nxt;
        setpoint_r  <= setpoint_nxt;
        temp_r      <= temp_nxt;
        heating_r   <= heating_nxt;
        heater_r    <= heater_nxt;
        cooler_r    <= cooler_nxt;
        blink_cnt_r <= blink_cnt_nxt;
        blink_ph_r  <= blink_ph_nxt;
        led_r       <= led_nxt;
        disp_en_r   <= disp_en_nxt;
        disp_val_r  <= disp_val_nxt;
      end
      if (advance) begin
        rsp_valid_r <= req_valid_r;
      end
      if (cfg_write) begin
        case (cfg_index)
          htc_pkg::CFG_INIT_SETPOINT: begin
            setpoint_r      <= cfg_data[6:0];
          end
          htc_pkg::CFG_BAND:        band_r        <= cfg_data[3:0];
          htc_pkg::CFG_STEP:        step_r        <= cfg_data[3:0];
          htc_pkg::CFG_CEILING:     ceiling_r     <= cfg_data[6:0];
          htc_pkg::CFG_BLINK_COUNT: blink_count_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid_r && advance) begin
      rsp_r.heater_on       <= heater_nxt;
      rsp_r.cooler_on       <= cooler_nxt;
      rsp_r.led_level       <= led_nxt;
      rsp_r.display_enable  <= disp_en_nxt;
      rsp_r.display_value   <= disp_en_nxt ? disp_val_nxt : 9'd0;
      rsp_r.powered         <= power_nxt;
      rsp_r.operating_mode  <= mode_nxt;
      rsp_r.setpoint_now    <= setpoint_nxt;
      rsp_r.store_strobe    <= strobe_nxt;
      rsp_r.temperature_now <= temp_nxt;
    end
  end

  assign out_valid           = rsp_valid_r;
  assign out_heater_on       = rsp_r.heater_on;
  assign out_cooler_on       = rsp_r.cooler_on;
  assign out_led_level       = rsp_r.led_level;
  assign out_display_enable  = rsp_r.display_enable;
  assign out_display_value   = rsp_r.display_value;
  assign out_powered         = rsp_r.powered;
  assign out_operating_mode  = rsp_r.operating_mode;
  assign out_setpoint_now    = rsp_r.setpoint_now;
  assign out_store_strobe    = rsp_r.store_strobe;
  assign out_temperature_now = rsp_r.temperature_now;

endmodule

// ===== tb/hysteresis_thermostat_controller_top_test.sv =====
// self-checking testbench for the hysteresis thermostat controller
module hysteresis_thermostat_controller_top_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] EV_SPARE_LO = htc_pkg::EV_LED + 3'd1;
  localparam logic [2:0] EV_SPARE_HI = htc_pkg::EV_LED + 3'd2;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_event_kind = htc_pkg::EV_POWER;
  logic       in_up_pressed = 1'b0;
  logic       in_down_pressed = 1'b0;
  logic [9:0] in_adc_count = 10'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_heater_on;
  logic       out_cooler_on;
  logic       out_led_level;
  logic       out_display_enable;
  logic [8:0] out_display_value;
  logic       out_powered;
  logic       out_operating_mode;
  logic [6:0] out_setpoint_now;
  logic       out_store_strobe;
  logic [8:0] out_temperature_now;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = htc_pkg::CFG_INIT_SETPOINT;
  logic [7:0] cfg_data = 8'd0;

  hysteresis_thermostat_controller_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_event_kind       (in_event_kind),
    .in_up_pressed       (in_up_pressed),
    .in_down_pressed     (in_down_pressed),
    .in_adc_count        (in_adc_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_heater_on       (out_heater_on),
    .out_cooler_on       (out_cooler_on),
    .out_led_level       (out_led_level),
    .out_display_enable  (out_display_enable),
    .out_display_value   (out_display_value),
    .out_powered         (out_powered),
    .out_operating_mode  (out_operating_mode),
    .out_setpoint_now    (out_setpoint_now),
    .out_store_strobe    (out_store_strobe),
    .out_temperature_now (out_temperature_now),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // thermostat state as the block should hold it
  logic [6:0] c_ceiling, m_setpoint;
  logic [3:0] c_band, c_step;
  logic [7:0] c_blink, m_blink_cnt;
  logic [8:0] m_temp, m_show_val;
  logic       m_power, m_mode, m_active, m_heating, m_heater, m_cooler;
  logic       m_blink_phase, m_led, m_show_en;

  htc_pkg::rsp_t pending_status[$];
  int   send_idle_pct = 8;
  int   recv_idle_pct = 46;
  int   fail_count = 0;
  int   events_sent = 0;
  int   results_seen = 0;
  int   cycles = 0;

  task automatic thermostat_reset();
    c_band = htc_pkg::BAND_RST;
    c_step = htc_pkg::STEP_RST;
    c_ceiling = htc_pkg::CEILING_RST;
    c_blink = htc_pkg::BLINK_COUNT_RST;
    m_power = 1'b0;
    m_mode = 1'b0;
    m_active = 1'b1;
    m_setpoint = htc_pkg::INIT_SETPOINT_RST;
    m_temp = 9'd0;
    m_heating = 1'b0;
    m_heater = 1'b0;
    m_cooler = 1'b0;
    m_blink_cnt = 8'd0;
    m_blink_phase = 1'b0;
    m_led = 1'b0;
    m_show_en = 1'b0;
    m_show_val = 9'd0;
  endtask

  task automatic thermostat_config(input logic [2:0] idx, input logic [7:0] data);
    case (idx)
      htc_pkg::CFG_INIT_SETPOINT: begin
        m_setpoint = data[6:0];
      end
      htc_pkg::CFG_BAND:        c_band = data[3:0];
      htc_pkg::CFG_STEP:        c_step = data[3:0];
      htc_pkg::CFG_CEILING:     c_ceiling = data[6:0];
      htc_pkg::CFG_BLINK_COUNT: c_blink = data;
      default: ;
    endcase
  endtask

  function automatic htc_pkg::rsp_t thermostat_step(input logic [2:0] kind, input logic up,
                                                    input logic down, input logic [9:0] adc);
    htc_pkg::rsp_t r;
    logic          strobe;
    int unsigned   sum;
    int            t, sp, bd;
    strobe = 1'b0;
    case (kind)
      htc_pkg::EV_POWER: begin
        if (!m_power) begin
          m_power = 1'b1;
        end else begin
          m_show_en = 1'b0;
          m_show_val = 9'd0;
          m_power = 1'b0;
          m_heater = 1'b0;
          m_cooler = 1'b0;
        end
      end
      htc_pkg::EV_BUTTONS: begin
        if (m_power) begin
          m_active = 1'b1;
          if (up && m_setpoint < c_ceiling) begin
            sum = 32'(m_setpoint) + 32'(c_step);
            m_setpoint = (sum > htc_pkg::SETPOINT_MAX) ? htc_pkg::SETPOINT_MAX : sum[6:0];
          end
          if (down && m_setpoint >= c_step) m_setpoint = m_setpoint - {3'd0, c_step};
        end
      end
      htc_pkg::EV_SAMPLE: begin
        sum = (int'(adc) * 488) / 1000;
        m_temp = sum[8:0];
        if (m_mode) begin
          t = int'(m_temp);
          sp = int'(m_setpoint);
          bd = int'(c_band);
          if (t >= sp + bd) begin
            m_heater = 1'b0;
            m_heating = 1'b0;
            m_cooler = 1'b1;
          end
          if (t < sp - bd) begin
            m_heater = 1'b1;
            m_heating = 1'b1;
            m_cooler = 1'b0;
          end
        end
      end
      htc_pkg::EV_DISPLAY: begin
        if (m_power) begin
          if (!m_mode) begin
            m_blink_cnt = m_blink_cnt + 8'd1;
            m_show_en = m_blink_phase;
            m_show_val = m_blink_phase ? {2'b00, m_setpoint} : 9'd0;
            if (m_blink_cnt == c_blink) m_blink_phase = ~m_blink_phase;
          end else begin
            m_show_en = 1'b1;
            m_show_val = m_temp;
          end
        end
      end
      htc_pkg::EV_MODE: begin
        if (m_active) begin
          m_active = 1'b0;
          m_mode = 1'b0;
        end else begin
          strobe = 1'b1;
          m_mode = 1'b1;
        end
      end
      htc_pkg::EV_LED: m_led = m_heating ? ~m_led : 1'b1;
      default: ;
    endcase
    r.heater_on = m_heater;
    r.cooler_on = m_cooler;
    r.led_level = m_led;
    r.display_enable = m_show_en;
    r.display_value = m_show_en ? m_show_val : 9'd0;
    r.powered = m_power;
    r.operating_mode = m_mode;
    r.setpoint_now = m_setpoint;
    r.store_strobe = strobe;
    r.temperature_now = m_temp;
    return r;
  endfunction

  task automatic send_event(input logic [2:0] kind, input logic up, input logic down,
                            input logic [9:0] adc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_event_kind <= kind;
    in_up_pressed <= up;
    in_down_pressed <= down;
    in_adc_count <= adc;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(thermostat_step(kind, up, down, adc));
    events_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    thermostat_config(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [6:0] init, input logic [3:0] band,
                              input logic [3:0] step, input logic [6:0] ceil,
                              input logic [7:0] blink);
    wait_idle();
    write_reg(htc_pkg::CFG_BAND, {4'd0, band});
    write_reg(htc_pkg::CFG_STEP, {4'd0, step});
    write_reg(htc_pkg::CFG_CEILING, {1'b0, ceil});
    write_reg(htc_pkg::CFG_BLINK_COUNT, blink);
    write_reg(htc_pkg::CFG_INIT_SETPOINT, {1'b0, init});
  endtask

  task automatic apply_random_config();
    apply_config(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(1, 15)), 7'($urandom_range(0, 127)),
                 8'($urandom_range(0, 255)));
  endtask

  // adc count landing near one edge of the dead band
  function automatic logic [9:0] adc_near_band();
    int t, a;
    t = int'(m_setpoint) + ($urandom_range(0, 1) ? int'(c_band) : -int'(c_band));
    t = t + int'($urandom_range(0, 4)) - 2;
    if (t < 0) t = 0;
    if (t > 499) t = 499;
    a = (t * 1000 + 487) / 488 + int'($urandom_range(0, 1));
    if (a > 1023) a = 1023;
    return 10'(a);
  endfunction

  task automatic send_random_event();
    int         r;
    logic [2:0] kind;
    logic [9:0] adc;
    r = $urandom_range(0, 99);
    if (r < 8) kind = htc_pkg::EV_POWER;
    else if (r < 24) kind = htc_pkg::EV_BUTTONS;
    else if (r < 52) kind = htc_pkg::EV_SAMPLE;
    else if (r < 66) kind = htc_pkg::EV_DISPLAY;
    else if (r < 80) kind = htc_pkg::EV_MODE;
    else if (r < 94) kind = htc_pkg::EV_LED;
    else kind = $urandom_range(0, 1) ? EV_SPARE_LO : EV_SPARE_HI;
    adc = $urandom_range(0, 1) ? 10'($urandom_range(0, 1023)) : adc_near_band();
    send_event(kind, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), adc);
  endtask

  task automatic test_directed();
    send_event(htc_pkg::EV_SAMPLE, 1'b0, 1'b0, 10'h3ff);
    send_event(htc_pkg::EV_BUTTONS, 1'b1, 1'b0, 10'h000);
    send_event(htc_pkg::EV_DISPLAY, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_POWER, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_BUTTONS, 1'b1, 1'b1, 10'h000);
    send_event(htc_pkg::EV_BUTTONS, 1'b1, 1'b0, 10'h000);
    send_event(htc_pkg::EV_BUTTONS, 1'b0, 1'b1, 10'h000);
    send_event(htc_pkg::EV_BUTTONS, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_DISPLAY, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_MODE, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_MODE, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_SAMPLE, 1'b1, 1'b1, 10'h000);
    send_event(htc_pkg::EV_LED, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_LED, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_DISPLAY, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_SAMPLE, 1'b0, 1'b0, 10'h3ff);
    send_event(htc_pkg::EV_LED, 1'b0, 1'b0, 10'h000);
    send_event(EV_SPARE_LO, 1'b1, 1'b1, 10'h3ff);
    send_event(EV_SPARE_HI, 1'b1, 1'b0, 10'h155);
    send_event(htc_pkg::EV_SAMPLE, 1'b0, 1'b0, 10'd52);
    send_event(htc_pkg::EV_POWER, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_SAMPLE, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_MODE, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_POWER, 1'b0, 1'b0, 10'h2aa);
  endtask

  task automatic test_config_extremes();
    apply_config(7'd0, 4'd0, 4'd1, 7'd0, 8'd0);
    for (int i = htc_pkg::CFG_BLINK_COUNT + 1; i < 8; i++) begin
      write_reg(3'(i), 8'($urandom_range(0, 255)));
    end
    repeat (20) send_random_event();
    apply_config(htc_pkg::SETPOINT_MAX, 4'd15, 4'd15, htc_pkg::SETPOINT_MAX, 8'd255);
    repeat (20) send_random_event();
  endtask

  // enough display ticks in setting mode for the blink phase to flip
  task automatic test_blink();
    apply_config(7'd42, htc_pkg::BAND_RST, htc_pkg::STEP_RST, htc_pkg::CEILING_RST, 8'd3);
    if (!m_power) send_event(htc_pkg::EV_POWER, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_BUTTONS, 1'b0, 1'b0, 10'h000);
    send_event(htc_pkg::EV_MODE, 1'b0, 1'b0, 10'h000);
    repeat (260) send_event(htc_pkg::EV_DISPLAY, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 8 : 0;
      apply_random_config();
      for (int i = 0; i < 180; i++) begin
        if (phase == 0 && i == 90) wait_idle();
        send_random_event();
      end
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s expected %0d got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    htc_pkg::rsp_t want;
    if (out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("heater_on", int'(want.heater_on), int'(out_heater_on));
        check_field("cooler_on", int'(want.cooler_on), int'(out_cooler_on));
        check_field("led_level", int'(want.led_level), int'(out_led_level));
        check_field("display_enable", int'(want.display_enable),
                    int'(out_display_enable));
        check_field("display_value", int'(want.display_value), int'(out_display_value));
        check_field("powered", int'(want.powered), int'(out_powered));
        check_field("operating_mode", int'(want.operating_mode),
                    int'(out_operating_mode));
        check_field("setpoint_now", int'(want.setpoint_now), int'(out_setpoint_now));
        check_field("store_strobe", int'(want.store_strobe), int'(out_store_strobe));
        check_field("temperature_now", int'(want.temperature_now),
                    int'(out_temperature_now));
        results_seen++;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    thermostat_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_blink();
    test_random();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d events sent, %0d results checked", events_sent, results_seen);
    $display("covered power, buttons, samples, ticks, spare kinds and register extremes");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
